[hw/rtl/matrix3x3_inverse_macros.svh]
// assertion macros for the 3x3 matrix inverse
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// a result strobe must trace back to a start, checked with $past over depth
`define MI_ASSERT_PAST(label, sig, src, depth, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (sig) |-> $past(src, depth)) \
        else $error(msg);

`endif

[hw/rtl/mi_pkg.sv]
// shared constants and cofactor index tables for the 3x3 matrix inverse
package mi_pkg;

    localparam int NELEM = 9;
    localparam int NDET  = 3;

    typedef logic [3:0] idx_t;

    // adjugate entry i = m[a]*m[b] - m[c]*m[d], flat row-major indices
    localparam idx_t COF_IDX [NELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // determinant by expansion along row 0: m0j times adjugate entry j*3
    localparam idx_t DET_ADJ [NDET] = '{4'd0, 4'd3, 4'd6};

endpackage

[hw/rtl/matrix3x3_inverse.sv]
// 3x3 matrix inverse by adjugate, fully pipelined fixed point
//
// takes one matrix word per cycle (busy is always low) and returns the inverse
// and the determinant on a one-cycle done strobe; the receiver cannot stall,
// so every result must be taken in the cycle it shows. the nine restoring
// dividers resolve one quotient bit per pipeline stage (ELEM_WIDTH+1 stages),
// behind ten stages of products, adjugate, determinant, rounding and range
// check. a matrix with an exactly zero determinant comes back unchanged with
// singular set; any value that does not fit the element format saturates and
// sets overflow.
module matrix3x3_inverse import mi_pkg::*; #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] m00,
    input  logic signed [ELEM_WIDTH-1:0] m01,
    input  logic signed [ELEM_WIDTH-1:0] m02,
    input  logic signed [ELEM_WIDTH-1:0] m10,
    input  logic signed [ELEM_WIDTH-1:0] m11,
    input  logic signed [ELEM_WIDTH-1:0] m12,
    input  logic signed [ELEM_WIDTH-1:0] m20,
    input  logic signed [ELEM_WIDTH-1:0] m21,
    input  logic signed [ELEM_WIDTH-1:0] m22,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] r00,
    output logic signed [ELEM_WIDTH-1:0] r01,
    output logic signed [ELEM_WIDTH-1:0] r02,
    output logic signed [ELEM_WIDTH-1:0] r10,
    output logic signed [ELEM_WIDTH-1:0] r11,
    output logic signed [ELEM_WIDTH-1:0] r12,
    output logic signed [ELEM_WIDTH-1:0] r20,
    output logic signed [ELEM_WIDTH-1:0] r21,
    output logic signed [ELEM_WIDTH-1:0] r22,
    output logic signed [ELEM_WIDTH-1:0] det_out,
    output logic                         singular,
    output logic                         overflow
);

    localparam int E   = ELEM_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int AW  = 2 * E + 1;           // adjugate entry, signed
    localparam int HW  = AW - E;              // upper slice of adjugate
    localparam int DTW = 3 * E + 3;           // determinant, signed
    localparam int RW  = (DTW > 2 * F ? DTW : 2 * F) + 1;  // det rounding sum
    localparam int NW  = 2 * E + 2 * F + 3;   // dividend
    localparam int SW  = DTW + E + 3;         // divisor shifted to the top bit
    localparam int WW  = (NW > SW) ? NW : SW; // divider datapath
    localparam int NQ  = E + 1;               // quotient bits resolved
    localparam int LAT = NQ + 10;

    localparam logic [RW-1:0] DET_HALF = RW'(1) << (2 * F - 1);
    localparam logic [RW-1:0] DET_MAXP = RW'((64'd1 << (E - 1)) - 64'd1);
    localparam logic [RW-1:0] DET_MAXN = RW'(64'd1 << (E - 1));
    localparam logic [NQ-1:0] Q_MAXP   = NQ'((64'd1 << (E - 1)) - 64'd1);
    localparam logic [NQ-1:0] Q_MAXN   = NQ'(64'd1 << (E - 1));
    localparam logic signed [E-1:0] EMAX = {1'b0, {(E-1){1'b1}}};
    localparam logic signed [E-1:0] EMIN = {1'b1, {(E-1){1'b0}}};

    // no backpressure anywhere: a word is taken every cycle
    assign busy = 1'b0;

    logic signed [E-1:0] m_in [NELEM];
    always_comb
    begin
        m_in[0] = m00; m_in[1] = m01; m_in[2] = m02;
        m_in[3] = m10; m_in[4] = m11; m_in[5] = m12;
        m_in[6] = m20; m_in[7] = m21; m_in[8] = m22;
    end

    // stage valid bits
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg;

    // stage 1: input register
    logic signed [E-1:0] s1_m_reg [NELEM];

    // stage 2: cofactor products
    logic signed [E-1:0]     s2_m_reg [NELEM];
    logic signed [2*E-1:0]   s2_pa_reg [NELEM];
    logic signed [2*E-1:0]   s2_pb_reg [NELEM];

    // stage 3: adjugate
    logic signed [E-1:0]     s3_m_reg [NELEM];
    logic signed [AW-1:0]    s3_adj_reg [NELEM];

    // stage 4: determinant partial products
    logic signed [E-1:0]     s4_m_reg [NELEM];
    logic signed [AW-1:0]    s4_adj_reg [NELEM];
    logic signed [2*E:0]     s4_pl_reg [NDET];
    logic signed [2*E:0]     s4_ph_reg [NDET];

    // stage 5: determinant terms
    logic signed [E-1:0]     s5_m_reg [NELEM];
    logic signed [AW-1:0]    s5_adj_reg [NELEM];
    logic signed [DTW-1:0]   s5_term_reg [NDET];

    // stage 6: determinant
    logic signed [E-1:0]     s6_m_reg [NELEM];
    logic signed [AW-1:0]    s6_adj_reg [NELEM];
    logic signed [DTW-1:0]   s6_det_reg;

    // stage 7: magnitudes and signs
    logic signed [E-1:0]     s7_m_reg [NELEM];
    logic [AW-1:0]           s7_aabs_reg [NELEM];
    logic [NELEM-1:0]        s7_neg_reg;
    logic [DTW-1:0]          s7_dabs_reg;
    logic                    s7_dneg_reg;
    logic                    s7_zero_reg;

    // stage 8: dividends, divisor, rounded determinant magnitude
    logic signed [E-1:0]     s8_m_reg [NELEM];
    logic [WW-1:0]           s8_num_reg [NELEM];
    logic [WW-1:0]           s8_dv_reg;
    logic [NELEM-1:0]        s8_neg_reg;
    logic [RW-1:0]           s8_dt_reg;
    logic                    s8_dneg_reg;
    logic                    s8_zero_reg;

    // divider stages: index 0 holds the range check, 1..NQ one quotient bit each
    logic                    dv_v_reg    [NQ+1];
    logic [WW-1:0]           dv_rem_reg  [NQ+1][NELEM];
    logic [NQ-1:0]           dv_q_reg    [NQ+1][NELEM];
    logic [WW-1:0]           dv_d_reg    [NQ+1];
    logic [NELEM-1:0]        dv_neg_reg  [NQ+1];
    logic [NELEM-1:0]        dv_over_reg [NQ+1];
    logic signed [E-1:0]     dv_m_reg    [NQ+1][NELEM];
    logic signed [E-1:0]     dv_det_reg  [NQ+1];
    logic                    dv_detov_reg[NQ+1];
    logic                    dv_zero_reg [NQ+1];

    // output register
    logic                    done_reg;
    logic signed [E-1:0]     r_reg [NELEM];
    logic signed [E-1:0]     det_reg;
    logic                    sing_reg;
    logic                    ovf_reg;

    // combinational next values
    logic signed [2*E-1:0]   s2_pa_next [NELEM];
    logic signed [2*E-1:0]   s2_pb_next [NELEM];
    logic signed [AW-1:0]    s3_adj_next [NELEM];
    logic signed [2*E:0]     s4_pl_next [NDET];
    logic signed [2*E:0]     s4_ph_next [NDET];
    logic signed [DTW-1:0]   s5_term_next [NDET];
    logic [NELEM-1:0]        dv0_over_next;
    logic signed [E-1:0]     dv0_det_next;
    logic                    dv0_detov_next;
    logic signed [E-1:0]     r_next [NELEM];
    logic                    lane_ov_next;

    always_comb
    begin
        for (int i = 0; i < NELEM; i++)
        begin
            s2_pa_next[i] = s1_m_reg[COF_IDX[i][0]] * s1_m_reg[COF_IDX[i][1]];
            s2_pb_next[i] = s1_m_reg[COF_IDX[i][2]] * s1_m_reg[COF_IDX[i][3]];
            s3_adj_next[i] = AW'(s2_pa_reg[i]) - AW'(s2_pb_reg[i]);
        end
        // adjugate split into an unsigned low slice and a signed high slice
        for (int j = 0; j < NDET; j++)
        begin
            s4_pl_next[j] = s3_m_reg[j]
                          * $signed({1'b0, s3_adj_reg[DET_ADJ[j]][E-1:0]});
            s4_ph_next[j] = s3_m_reg[j] * $signed(s3_adj_reg[DET_ADJ[j]][AW-1:E]);
            s5_term_next[j] = (DTW'(s4_ph_reg[j]) <<< E) + DTW'(s4_pl_reg[j]);
        end
    end

    // determinant saturation and quotient range check
    always_comb
    begin
        for (int i = 0; i < NELEM; i++)
            dv0_over_next[i] = s8_num_reg[i] >= (s8_dv_reg << NQ);
        dv0_detov_next = s8_dneg_reg ? (s8_dt_reg > DET_MAXN) : (s8_dt_reg > DET_MAXP);
        if (dv0_detov_next)
            dv0_det_next = s8_dneg_reg ? EMIN : EMAX;
        else if (s8_dneg_reg)
            dv0_det_next = -$signed(s8_dt_reg[E-1:0]);
        else
            dv0_det_next = $signed(s8_dt_reg[E-1:0]);
    end

    // sign, saturate, singular bypass
    always_comb
    begin
        lane_ov_next = 1'b0;
        for (int i = 0; i < NELEM; i++)
        begin
            if (dv_over_reg[NQ][i] || (dv_neg_reg[NQ][i] ? (dv_q_reg[NQ][i] > Q_MAXN)
                                                          : (dv_q_reg[NQ][i] > Q_MAXP)))
            begin
                r_next[i]    = dv_neg_reg[NQ][i] ? EMIN : EMAX;
                lane_ov_next = 1'b1;
            end
            else if (dv_neg_reg[NQ][i])
                r_next[i] = -$signed(dv_q_reg[NQ][i][E-1:0]);
            else
                r_next[i] = $signed(dv_q_reg[NQ][i][E-1:0]);
            if (dv_zero_reg[NQ])
                r_next[i] = dv_m_reg[NQ][i];
        end
    end

    // valid chain, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0; s2_v_reg <= 1'b0; s3_v_reg <= 1'b0; s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0; s6_v_reg <= 1'b0; s7_v_reg <= 1'b0; s8_v_reg <= 1'b0;
            for (int s = 0; s <= NQ; s++)
                dv_v_reg[s] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg; s3_v_reg <= s2_v_reg; s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg; s6_v_reg <= s5_v_reg; s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
            dv_v_reg[0] <= s8_v_reg;
            for (int s = 0; s < NQ; s++)
                dv_v_reg[s+1] <= dv_v_reg[s];
            done_reg <= dv_v_reg[NQ];
        end
    end

    // front datapath
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NELEM; i++)
        begin
            s1_m_reg[i]   <= m_in[i];
            s2_m_reg[i]   <= s1_m_reg[i];
            s2_pa_reg[i]  <= s2_pa_next[i];
            s2_pb_reg[i]  <= s2_pb_next[i];
            s3_m_reg[i]   <= s2_m_reg[i];
            s3_adj_reg[i] <= s3_adj_next[i];
            s4_m_reg[i]   <= s3_m_reg[i];
            s4_adj_reg[i] <= s3_adj_reg[i];
            s5_m_reg[i]   <= s4_m_reg[i];
            s5_adj_reg[i] <= s4_adj_reg[i];
            s6_m_reg[i]   <= s5_m_reg[i];
            s6_adj_reg[i] <= s5_adj_reg[i];
            s7_m_reg[i]   <= s6_m_reg[i];
            s7_aabs_reg[i] <= s6_adj_reg[i][AW-1] ? AW'(-s6_adj_reg[i])
                                                  : AW'(s6_adj_reg[i]);
            s7_neg_reg[i] <= s6_adj_reg[i][AW-1] != s6_det_reg[DTW-1];
            s8_m_reg[i]   <= s7_m_reg[i];
            // 2|A|*2^(2F) + |D| over 2|D| gives round half away from zero
            s8_num_reg[i] <= (WW'(s7_aabs_reg[i]) << (2 * F + 1)) + WW'(s7_dabs_reg);
        end
        for (int j = 0; j < NDET; j++)
        begin
            s4_pl_reg[j]   <= s4_pl_next[j];
            s4_ph_reg[j]   <= s4_ph_next[j];
            s5_term_reg[j] <= s5_term_next[j];
        end
        s6_det_reg  <= s5_term_reg[0] + s5_term_reg[1] + s5_term_reg[2];
        s7_dabs_reg <= s6_det_reg[DTW-1] ? DTW'(-s6_det_reg) : DTW'(s6_det_reg);
        s7_dneg_reg <= s6_det_reg[DTW-1];
        s7_zero_reg <= s6_det_reg == '0;
        s8_dv_reg   <= WW'(s7_dabs_reg) << 1;
        s8_neg_reg  <= s7_neg_reg;
        s8_dt_reg   <= (RW'(s7_dabs_reg) + DET_HALF) >> (2 * F);
        s8_dneg_reg <= s7_dneg_reg;
        s8_zero_reg <= s7_zero_reg;

        // range check stage
        for (int i = 0; i < NELEM; i++)
        begin
            dv_rem_reg[0][i] <= s8_num_reg[i];
            dv_q_reg[0][i]   <= '0;
            dv_m_reg[0][i]   <= s8_m_reg[i];
        end
        dv_d_reg[0]     <= s8_dv_reg;
        dv_neg_reg[0]   <= s8_neg_reg;
        dv_over_reg[0]  <= dv0_over_next;
        dv_det_reg[0]   <= dv0_det_next;
        dv_detov_reg[0] <= dv0_detov_next;
        dv_zero_reg[0]  <= s8_zero_reg;

        // output word
        r_reg    <= r_next;
        det_reg  <= dv_zero_reg[NQ] ? '0 : dv_det_reg[NQ];
        sing_reg <= dv_zero_reg[NQ];
        ovf_reg  <= !dv_zero_reg[NQ] && (lane_ov_next || dv_detov_reg[NQ]);
    end

    // restoring divider, one quotient bit per stage from the top down
    for (genvar s = 0; s < NQ; s++)
    begin : g_div
        localparam int K = NQ - 1 - s;
        logic [WW-1:0] trial_next;
        assign trial_next = dv_d_reg[s] << K;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < NELEM; i++)
            begin
                if (dv_rem_reg[s][i] >= trial_next)
                begin
                    dv_rem_reg[s+1][i] <= dv_rem_reg[s][i] - trial_next;
                    dv_q_reg[s+1][i]   <= dv_q_reg[s][i] | (NQ'(1) << K);
                end
                else
                begin
                    dv_rem_reg[s+1][i] <= dv_rem_reg[s][i];
                    dv_q_reg[s+1][i]   <= dv_q_reg[s][i];
                end
                dv_m_reg[s+1][i] <= dv_m_reg[s][i];
            end
            dv_d_reg[s+1]     <= dv_d_reg[s];
            dv_neg_reg[s+1]   <= dv_neg_reg[s];
            dv_over_reg[s+1]  <= dv_over_reg[s];
            dv_det_reg[s+1]   <= dv_det_reg[s];
            dv_detov_reg[s+1] <= dv_detov_reg[s];
            dv_zero_reg[s+1]  <= dv_zero_reg[s];
        end
    end

    assign done     = done_reg;
    assign r00      = r_reg[0];
    assign r01      = r_reg[1];
    assign r02      = r_reg[2];
    assign r10      = r_reg[3];
    assign r11      = r_reg[4];
    assign r12      = r_reg[5];
    assign r20      = r_reg[6];
    assign r21      = r_reg[7];
    assign r22      = r_reg[8];
    assign det_out  = det_reg;
    assign singular = sing_reg;
    assign overflow = ovf_reg;

    `include "matrix3x3_inverse_macros.svh"

    // a singular word never reports saturation and carries a zero determinant
    `MI_ASSERT_IMP(a_sing_no_ovf, done && singular, !overflow, "singular word flagged overflow")
    `MI_ASSERT_IMP(a_sing_det_zero, done && singular, det_out == '0, "singular word with det")
    // every result strobe comes from a matching earlier start
    `MI_ASSERT_PAST(a_latency, done, start, LAT, "result without matching start")

endmodule
